/* hdl/mie_pkg.sv */
// shared types and constants for the modular inverse unit
package mie_pkg;

  localparam int WIDTH  = 32;
  localparam int COEF_W = WIDTH + 2;
  localparam int CNT_W  = $clog2(WIDTH);

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
  } mie_item_t;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;
  } mie_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH
  } mie_state_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHIFT,
    CMD_SUB
  } mie_cmd_t;

  typedef struct packed {
    mie_cmd_t cmd;
    logic     align;
  } mie_ctrl_t;

  typedef struct packed {
    logic b_zero;
    logic can_shift;
    logic cnt_zero;
  } mie_status_t;

endpackage

/* hdl/mie_ctrl.sv */
// sequencer for the euclid steps: align, shift-subtract, finish
module mie_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                out_free,
  output logic                out_load,
  input  mie_pkg::mie_status_t status,
  output mie_pkg::mie_ctrl_t   ctrl
);
  import mie_pkg::*;

  mie_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    out_load   = 1'b0;
    ctrl.cmd   = CMD_HOLD;
    // operand select depends on state only, so status never loops back
    ctrl.align = (state == ST_ALIGN);
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctrl.cmd   = CMD_LOAD;
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (status.b_zero) begin
          state_next = ST_FINISH;
        end else if (status.can_shift) begin
          ctrl.cmd = CMD_SHIFT;
        end else begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        ctrl.cmd = CMD_SUB;
        if (status.cnt_zero) begin
          state_next = ST_ALIGN;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded while output slot busy");

  a_sub_leaves_to_align: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUB && status.cnt_zero) |=> (state == ST_ALIGN))
    else $error("step end did not return to align");

endmodule

/* hdl/mie_dp.sv */
// remainder and coefficient registers around one shared compare-subtract unit
module mie_dp (
  input  logic                 clk,
  input  mie_pkg::mie_ctrl_t   ctrl,
  input  mie_pkg::mie_item_t   item,
  output mie_pkg::mie_status_t status,
  output mie_pkg::mie_result_t result
);
  import mie_pkg::*;

  // a/ta: running remainder and its coefficient, b/tb: divisor and its coefficient
  // d/td: divisor and coefficient scaled by 2^cnt
  logic [WIDTH-1:0]        a, b, d, m;
  logic signed [COEF_W-1:0] ta, tb, td;
  logic [CNT_W-1:0]        cnt;

  logic [WIDTH-1:0]         opnd;
  logic [WIDTH:0]           diff;
  logic                     ge;
  logic [WIDTH-1:0]         a_new;
  logic signed [COEF_W-1:0] ta_sub, ta_new, ta_plus_m;

  // shared compare-subtract: against 2*d while aligning, d while dividing
  always_comb begin
    opnd      = ctrl.align ? {d[WIDTH-2:0], 1'b0} : d;
    diff      = {1'b0, a} - {1'b0, opnd};
    ge        = ~diff[WIDTH];
    ta_sub    = ta - td;
    a_new     = ge ? diff[WIDTH-1:0] : a;
    ta_new    = ge ? ta_sub : ta;
    ta_plus_m = ta + $signed({2'b00, m});
  end

  assign status.b_zero    = (b == '0);
  assign status.can_shift = ~d[WIDTH-1] & ge;
  assign status.cnt_zero  = (cnt == '0);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        a   <= item.modulus;
        m   <= item.modulus;
        ta  <= '0;
        b   <= item.value;
        d   <= item.value;
        tb  <= COEF_W'(1);
        td  <= COEF_W'(1);
        cnt <= '0;
      end
      CMD_SHIFT: begin
        d   <= {d[WIDTH-2:0], 1'b0};
        td  <= td <<< 1;
        cnt <= cnt + CNT_W'(1);
      end
      CMD_SUB: begin
        if (cnt != '0) begin
          a   <= a_new;
          ta  <= ta_new;
          d   <= d >> 1;
          td  <= td >>> 1;
          cnt <= cnt - CNT_W'(1);
        end else begin
          // last quotient bit: rotate to the next remainder pair
          a  <= b;
          ta <= tb;
          b  <= a_new;
          tb <= ta_new;
          d  <= a_new;
          td <= ta_new;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (a != WIDTH'(1)) begin
      result.inverse    = WIDTH'(1);
      result.no_inverse = 1'b1;
    end else if (m == WIDTH'(1)) begin
      result.inverse    = '0;
      result.no_inverse = 1'b0;
    end else begin
      result.inverse    = ta[COEF_W-1] ? ta_plus_m[WIDTH-1:0] : ta[WIDTH-1:0];
      result.no_inverse = 1'b0;
    end
  end

  a_scaled_back: assert property (@(posedge clk)
    (ctrl.cmd == CMD_SUB && cnt == '0) |-> (d == b && td == tb))
    else $error("scaled divisor not restored at step end");

  a_remainder_drops: assert property (@(posedge clk)
    (ctrl.cmd == CMD_SUB && cnt == '0) |=> (b < $past(b)))
    else $error("remainder did not decrease");

  a_shift_no_overflow: assert property (@(posedge clk)
    (ctrl.cmd == CMD_SHIFT) |-> !d[WIDTH-1])
    else $error("divisor shifted past top bit");

endmodule

/* hdl/modular_inverse_ext_euclid_unit.sv */
// modular inverse by extended euclid: one item in, one result beat out
// the compare-subtract unit aligns and divides one bit a cycle
// one item in flight: a new beat is taken once the unit is back in idle, even while the
// previous result still waits at the output
// rst is synchronous, active high, and clears the sequencer and output valid
module modular_inverse_ext_euclid_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mie_pkg::mie_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output mie_pkg::mie_result_t result
);
  import mie_pkg::*;

  mie_ctrl_t   ctrl;
  mie_status_t status;
  mie_result_t dp_result;
  logic        out_free;
  logic        out_load;

  assign out_free = ~result_valid | result_ready;

  mie_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_free   (out_free),
    .out_load   (out_load),
    .status     (status),
    .ctrl       (ctrl)
  );

  mie_dp u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .item   (item),
    .status (status),
    .result (dp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= dp_result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("pending result beat overwritten");

endmodule

/* bench/testbench.sv */
// testbench for the modular inverse unit: directed table, then random bursts checked by a predictor
`timescale 1ns / 100ps

module testbench;
  import mie_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int TAIL_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
    logic             known;   // expected result typed into the row
    mie_result_t      want;
  } stim_row_t;

  typedef struct {
    mie_item_t   src;
    mie_result_t want;
  } inverse_due_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  mie_item_t   item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  mie_result_t result;

  inverse_due_t inverses_due [$];
  stim_row_t    directed_rows [23];
  int unsigned  mismatches   = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  rx_cycle     = 0;

  modular_inverse_ext_euclid_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #CLK_HALF clk = ~clk;

  // extended euclid on (modulus, value); coefficients wrap at 64 bits
  function automatic mie_result_t predict_inverse(logic [WIDTH-1:0] value,
                                                  logic [WIDTH-1:0] modulus);
    logic [63:0] r_prev, r_cur, r_next;
    logic [63:0] t_prev, t_cur, t_next;
    logic [63:0] quot, coef;
    mie_result_t res;
    r_prev = 64'(modulus);
    r_cur  = 64'(value);
    t_prev = 64'd0;
    t_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quot   = r_prev / r_cur;
      r_next = r_prev - quot * r_cur;
      t_next = t_prev - quot * t_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    if (r_prev != 64'd1) begin
      res.inverse    = WIDTH'(1);
      res.no_inverse = 1'b1;
    end else begin
      coef = t_prev[63] ? t_prev + 64'(modulus) : t_prev;
      if (modulus != '0 && coef >= 64'(modulus))
        coef = coef % 64'(modulus);
      res.inverse    = coef[WIDTH-1:0];
      res.no_inverse = 1'b0;
    end
    return res;
  endfunction

  function automatic mie_item_t random_item();
    mie_item_t        it;
    logic [WIDTH-1:0] fib_lo, fib_hi, fib_nx, factor;
    int unsigned      pick, steps;
    pick       = $urandom_range(0, 99);
    it.value   = $urandom;
    it.modulus = $urandom_range(32'hFFFFFFFF, 1);
    if (pick < 15) begin
      it.modulus = $urandom_range(255, 1);
    end else if (pick < 25) begin
      it.value   = $urandom_range(64, 0);
      it.modulus = $urandom_range(64, 1);
    end else if (pick < 35) begin
      // shared factor, mostly no inverse
      factor     = $urandom_range(1000, 2);
      it.value   = factor * $urandom_range(32'h003FFFFF, 0);
      it.modulus = factor * $urandom_range(32'h003FFFFF, 1);
    end else if (pick < 40) begin
      it.modulus = $urandom_range(2, 1);
    end else if (pick < 45) begin
      it.value = it.modulus - $urandom_range(3, 0);
    end else if (pick < 50) begin
      // consecutive fibonacci numbers give the longest remainder chains
      fib_lo = 1;
      fib_hi = 1;
      steps  = $urandom_range(45, 2);
      repeat (steps) begin
        fib_nx = fib_lo + fib_hi;
        fib_lo = fib_hi;
        fib_hi = fib_nx;
      end
      it.value   = fib_lo;
      it.modulus = fib_hi;
    end else if (pick < 52) begin
      it.modulus = '0;
    end
    return it;
  endfunction

  task automatic send_item(input mie_item_t src, input mie_result_t want);
    item       <= src;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    inverses_due.push_back('{src: src, want: want});
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (inverses_due.size() != 0);
  endtask

  // receiver: phases of always ready, light stalls and heavy stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 700) % 3)
      0:       result_ready <= 1'b1;
      1:       result_ready <= ($urandom_range(0, 3) != 0);
      default: result_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    inverse_due_t due;
    if (!rst && result_valid && result_ready) begin
      if (inverses_due.size() == 0) begin
        $error("result beat with nothing outstanding: inverse %0h no_inverse %0b",
               result.inverse, result.no_inverse);
        mismatches++;
      end else begin
        due = inverses_due.pop_front();
        if (result.inverse !== due.want.inverse) begin
          $error("inverse: expected %0h, got %0h (value %0h modulus %0h)",
                 due.want.inverse, result.inverse, due.src.value, due.src.modulus);
          mismatches++;
        end
        if (result.no_inverse !== due.want.no_inverse) begin
          $error("no_inverse: expected %0b, got %0b (value %0h modulus %0h)",
                 due.want.no_inverse, result.no_inverse, due.src.value, due.src.modulus);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned sent, burst, gap;
    bit          drained_mid;
    mie_result_t want;
    stim_row_t   row;
    sent        = 0;
    drained_mid = 1'b0;
    directed_rows = '{
      '{32'h00000000, 32'h00000001, 1'b1, '{32'h00000000, 1'b0}},  // modulus one
      '{32'hFFFFFFFF, 32'h00000001, 1'b1, '{32'h00000000, 1'b0}},
      '{32'h00000000, 32'hFFFFFFFF, 1'b1, '{32'h00000001, 1'b1}},  // value zero
      '{32'h00000001, 32'hFFFFFFFF, 1'b1, '{32'h00000001, 1'b0}},
      '{32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFE, 1'b0}},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'h00000001, 1'b1}},
      '{32'h00000000, 32'h00000000, 1'b1, '{32'h00000001, 1'b1}},  // modulus zero
      '{32'h00000001, 32'h00000000, 1'b1, '{32'h00000001, 1'b0}},
      '{32'hFFFFFFFF, 32'h00000000, 1'b1, '{32'h00000001, 1'b1}},
      '{32'h00003039, 32'h00000000, 1'b1, '{32'h00000001, 1'b1}},
      '{32'h00000002, 32'h00000004, 1'b1, '{32'h00000001, 1'b1}},
      '{32'hAAAAAAAA, 32'h55555555, 1'b1, '{32'h00000001, 1'b1}},
      '{32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, '{32'h00000001, 1'b0}},  // value above modulus
      '{32'hFFFFFFFF, 32'h00000002, 1'b1, '{32'h00000001, 1'b0}},
      '{32'h00000001, 32'h00000002, 1'b1, '{32'h00000001, 1'b0}},
      '{32'h00000002, 32'hFFFFFFFF, 1'b1, '{32'h80000000, 1'b0}},
      '{32'h00000003, 32'h00000007, 1'b0, '{32'h00000000, 1'b0}},
      '{32'h00000005, 32'h00000003, 1'b0, '{32'h00000000, 1'b0}},
      '{32'h6D73E55F, 32'hB11924E1, 1'b0, '{32'h00000000, 1'b0}},  // longest chain
      '{32'h80000000, 32'hFFFFFFFF, 1'b0, '{32'h00000000, 1'b0}},
      '{32'h12345678, 32'hFFFFFFFB, 1'b0, '{32'h00000000, 1'b0}},
      '{32'hFFFFFFFA, 32'hFFFFFFFB, 1'b0, '{32'h00000000, 1'b0}},
      '{32'h55555555, 32'hAAAAAAAB, 1'b0, '{32'h00000000, 1'b0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.known ? row.want : predict_inverse(row.value, row.modulus);
      send_item('{value: row.value, modulus: row.modulus}, want);
    end
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(24, 1);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_one: begin
          mie_item_t src;
          src = random_item();
          send_item(src, predict_inverse(src.value, src.modulus));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(40, 1);
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // hold off once until the unit has handed back every result
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
